// File: hw/rtl/pdcc_pkg.sv
// ----------------------------------------------------------------------------
// pdcc_pkg
// shared widths, payload structs and register codes for the dir coupler
// exposure correction pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package pdcc_pkg;

  // sample and fixed point layout
  localparam int SAMPLE_WIDTH = 16;
  localparam int FRAC_BITS    = 12;
  localparam int INV_W        = 16;
  localparam int SHIFT_W      = 16;
  localparam int COEF_W       = 18;
  localparam int NUM_CH       = 3;
  localparam int ROW_W        = NUM_CH * COEF_W;

  // normalize path widths
  localparam int NORM_W   = 20;
  localparam int PROD_W   = SAMPLE_WIDTH + INV_W;
  localparam int SQ_W     = 2 * NORM_W - FRAC_BITS;
  localparam int SHPROD_W = SHIFT_W + SQ_W + 1;
  localparam int BENT_W   = SHPROD_W - FRAC_BITS;

  // matrix path widths
  localparam int CPROD_W   = BENT_W + COEF_W;
  localparam int ACC_W     = CPROD_W + 3;
  localparam int OUT_SHIFT = 16;

  // pipeline depth
  localparam int NORM_STAGES    = 6;
  localparam int COUPLER_STAGES = 3;
  localparam int NUM_STAGES     = NORM_STAGES + COUPLER_STAGES;

  localparam int CFG_ADDR_W = 3;

  typedef logic [NUM_STAGES-1:0] stage_en_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ROW_CYAN    = 3'd0,
    REG_ROW_MAGENTA = 3'd1,
    REG_ROW_YELLOW  = 3'd2,
    REG_INV_CYAN    = 3'd3,
    REG_INV_MAGENTA = 3'd4,
    REG_INV_YELLOW  = 3'd5,
    REG_SHIFT       = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] raw_red;
    logic signed [SAMPLE_WIDTH-1:0] raw_green;
    logic signed [SAMPLE_WIDTH-1:0] raw_blue;
    logic        [SAMPLE_WIDTH-1:0] dens_cyan;
    logic        [SAMPLE_WIDTH-1:0] dens_magenta;
    logic        [SAMPLE_WIDTH-1:0] dens_yellow;
  } pix_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] fixed_red;
    logic signed [SAMPLE_WIDTH-1:0] fixed_green;
    logic signed [SAMPLE_WIDTH-1:0] fixed_blue;
  } res_t;

endpackage

`default_nettype wire

// File: hw/rtl/pdcc_norm.sv
// ----------------------------------------------------------------------------
// pdcc_norm
// one density channel: scale by reciprocal, clamp, square, apply quadratic bend
// ----------------------------------------------------------------------------
`default_nettype none

module pdcc_norm
  import pdcc_pkg::*;
(
  input  wire logic                     clk,
  input  wire stage_en_t                en,
  input  wire logic [SAMPLE_WIDTH-1:0]  dens,
  input  wire logic [INV_W-1:0]         inv,
  input  wire logic signed [SHIFT_W-1:0] shift,
  output logic signed [BENT_W-1:0]      bent
);

  localparam int HALF = 1 << (FRAC_BITS - 1);
  localparam logic [NORM_W-1:0] NORM_MAX = '1;
  localparam int RND_W = PROD_W + 1 - FRAC_BITS;

  logic [PROD_W-1:0]         prod;
  logic [NORM_W-1:0]         norm1, norm2, norm3, norm4;
  logic [2*NORM_W-1:0]       nsq;
  logic [SQ_W-1:0]           sq;
  logic signed [SHPROD_W-1:0] shp;

  logic [PROD_W:0]            rnd;
  logic [NORM_W-1:0]          norm_next;
  logic [2*NORM_W:0]          sq_rnd;
  logic signed [SHPROD_W-1:0] shp_rnd;
  logic signed [BENT_W-1:0]   bent_next;

  always_comb begin
    rnd = {1'b0, prod} + (PROD_W + 1)'(HALF);
    // clamp to unsigned q8.12 before squaring
    if (rnd[PROD_W:FRAC_BITS] > RND_W'(NORM_MAX)) begin
      norm_next = NORM_MAX;
    end else begin
      norm_next = NORM_W'(rnd[PROD_W:FRAC_BITS]);
    end
    sq_rnd    = {1'b0, nsq} + (2 * NORM_W + 1)'(HALF);
    shp_rnd   = shp + $signed(SHPROD_W'(HALF));
    bent_next = $signed(shp_rnd[SHPROD_W-1:FRAC_BITS]) + $signed({1'b0, norm4});
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod <= PROD_W'(dens * inv);
    end
    if (en[1]) begin
      norm1 <= norm_next;
    end
    if (en[2]) begin
      nsq   <= norm1 * norm1;
      norm2 <= norm1;
    end
    if (en[3]) begin
      sq    <= sq_rnd[FRAC_BITS +: SQ_W];
      norm3 <= norm2;
    end
    if (en[4]) begin
      shp   <= shift * $signed({1'b0, sq});
      norm4 <= norm3;
    end
    if (en[5]) begin
      bent <= bent_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pdcc_coupler.sv
// ----------------------------------------------------------------------------
// pdcc_coupler
// one output channel: matrix column product, subtract from raw, round, saturate
// ----------------------------------------------------------------------------
`default_nettype none

module pdcc_coupler
  import pdcc_pkg::*;
(
  input  wire logic                           clk,
  input  wire stage_en_t                      en,
  input  wire logic signed [BENT_W-1:0]       bent [NUM_CH],
  input  wire logic [NUM_CH-1:0][COEF_W-1:0]  coef_col,
  input  wire logic signed [SAMPLE_WIDTH-1:0] raw,
  output logic signed [SAMPLE_WIDTH-1:0]      fixed
);

  localparam int RES_W    = ACC_W - OUT_SHIFT;
  localparam int SMAX     = (1 << (SAMPLE_WIDTH - 1)) - 1;
  localparam int OUT_HALF = 1 << (OUT_SHIFT - 1);
  localparam logic signed [RES_W-1:0] RES_MAX = RES_W'(SMAX);
  localparam logic signed [RES_W-1:0] RES_MIN = ~RES_MAX;

  logic signed [CPROD_W-1:0]      cprod [NUM_CH];
  logic signed [SAMPLE_WIDTH-1:0] raw6, raw7;
  logic signed [ACC_W-1:0]        acc;

  logic signed [ACC_W-1:0]        acc_next;
  logic signed [ACC_W-1:0]        total;
  logic signed [RES_W-1:0]        res;
  logic signed [SAMPLE_WIDTH-1:0] fixed_next;

  always_comb begin
    acc_next = '0;
    for (int k = 0; k < NUM_CH; k++) begin
      acc_next = acc_next + ACC_W'(cprod[k]);
    end
    total = (ACC_W'(raw7) <<< OUT_SHIFT) - acc + $signed(ACC_W'(OUT_HALF));
    res   = $signed(total[ACC_W-1:OUT_SHIFT]);
    if (res > RES_MAX) begin
      fixed_next = SAMPLE_WIDTH'(RES_MAX);
    end else if (res < RES_MIN) begin
      fixed_next = SAMPLE_WIDTH'(RES_MIN);
    end else begin
      fixed_next = SAMPLE_WIDTH'(res);
    end
  end

  always_ff @(posedge clk) begin
    if (en[NORM_STAGES]) begin
      for (int k = 0; k < NUM_CH; k++) begin
        cprod[k] <= bent[k] * $signed(coef_col[k]);
      end
      raw6 <= raw;
    end
    if (en[NORM_STAGES+1]) begin
      acc  <= acc_next;
      raw7 <= raw6;
    end
    if (en[NORM_STAGES+2]) begin
      fixed <= fixed_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pixel_dir_coupler_correction_top.sv
// ----------------------------------------------------------------------------
// pixel_dir_coupler_correction_top
// per pixel dir coupler exposure correction on log raw rgb using cmy densities
// ----------------------------------------------------------------------------
//
//  channel   signals                              dir   content
//  pixel     pix_valid, pix_stall, pix            in    raw rgb + cmy density
//  result    res_valid, res_stall, res            out   corrected log rgb
//  config    cfg_wr_en, cfg_addr, cfg_wdata       in    register writes
//
//  nine register stages, one pixel per clock when the result side does not
//  stall; the depth is set by the multiply chain reciprocal, square, bend and
//  matrix product, each followed by a register
//  each stage holds until the next one frees, so bubbles are squeezed out and
//  a stalled result only backs up the pipe as far as it is full
//  synchronous reset clears the stage valid bits and all config registers
//
`default_nettype none

module pixel_dir_coupler_correction_top
  import pdcc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // pixel transaction
  input  wire logic                  pix_valid,
  output logic                       pix_stall,
  input  wire pix_t                  pix,
  // result transaction
  output logic                       res_valid,
  input  wire logic                  res_stall,
  output res_t                       res,
  // config writes
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [ROW_W-1:0]      cfg_wdata
);

  // config registers
  logic [ROW_W-1:0]          coef_row [NUM_CH];
  logic [INV_W-1:0]          inv_dmax [NUM_CH];
  logic signed [SHIFT_W-1:0] high_exposure_shift;

  // pipeline control
  logic [NUM_STAGES-1:0] vld;
  stage_en_t             en;

  // per channel views of the payload
  logic signed [SAMPLE_WIDTH-1:0] raw_in [NUM_CH];
  logic [SAMPLE_WIDTH-1:0]        dens_in [NUM_CH];
  logic signed [BENT_W-1:0]       bent [NUM_CH];
  logic signed [SAMPLE_WIDTH-1:0] fixed [NUM_CH];

  // raw exposures ride alongside the normalize stages
  logic signed [SAMPLE_WIDTH-1:0] raw_d [NORM_STAGES][NUM_CH];

  assign raw_in[0]  = pix.raw_red;
  assign raw_in[1]  = pix.raw_green;
  assign raw_in[2]  = pix.raw_blue;
  assign dens_in[0] = pix.dens_cyan;
  assign dens_in[1] = pix.dens_magenta;
  assign dens_in[2] = pix.dens_yellow;

  assign res.fixed_red   = fixed[0];
  assign res.fixed_green = fixed[1];
  assign res.fixed_blue  = fixed[2];

  // config write decode, unknown index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_CH; k++) begin
        coef_row[k] <= '0;
        inv_dmax[k] <= '0;
      end
      high_exposure_shift <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_ROW_CYAN:    coef_row[0] <= cfg_wdata;
        REG_ROW_MAGENTA: coef_row[1] <= cfg_wdata;
        REG_ROW_YELLOW:  coef_row[2] <= cfg_wdata;
        REG_INV_CYAN:    inv_dmax[0] <= cfg_wdata[INV_W-1:0];
        REG_INV_MAGENTA: inv_dmax[1] <= cfg_wdata[INV_W-1:0];
        REG_INV_YELLOW:  inv_dmax[2] <= cfg_wdata[INV_W-1:0];
        REG_SHIFT:       high_exposure_shift <= $signed(cfg_wdata[SHIFT_W-1:0]);
        default: ;
      endcase
    end
  end

  // a stage may load when it is empty or when the stage after it moves
  always_comb begin
    logic nxt;
    nxt = !res_stall;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      en[i] = !vld[i] || nxt;
      nxt   = en[i];
    end
  end

  assign pix_stall = !en[0];
  assign res_valid = vld[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        if (en[i]) begin
          vld[i] <= (i == 0) ? pix_valid : vld[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NORM_STAGES; i++) begin
      if (en[i]) begin
        for (int k = 0; k < NUM_CH; k++) begin
          raw_d[i][k] <= (i == 0) ? raw_in[k] : raw_d[(i == 0) ? 0 : i - 1][k];
        end
      end
    end
  end

  // density normalize and bend, one unit per cmy channel
  for (genvar k = 0; k < NUM_CH; k++) begin : g_norm
    pdcc_norm u_norm (
      .clk   (clk),
      .en    (en),
      .dens  (dens_in[k]),
      .inv   (inv_dmax[k]),
      .shift (high_exposure_shift),
      .bent  (bent[k])
    );
  end

  // matrix column and correction, one unit per rgb output
  for (genvar m = 0; m < NUM_CH; m++) begin : g_coupler
    logic [NUM_CH-1:0][COEF_W-1:0] coef_col;

    for (genvar k = 0; k < NUM_CH; k++) begin : g_col
      assign coef_col[k] = coef_row[k][m*COEF_W +: COEF_W];
    end

    pdcc_coupler u_coupler (
      .clk      (clk),
      .en       (en),
      .bent     (bent),
      .coef_col (coef_col),
      .raw      (raw_d[NORM_STAGES-1][m]),
      .fixed    (fixed[m])
    );
  end

endmodule

`default_nettype wire

// File: tb/sv/pdcc_exposure_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdcc_exposure_checker
// watches the pixel, result and config ports of the coupler correction block,
// keeps its own copy of the registers, predicts each corrected pixel and
// compares it field by field against the results in arrival order
// ----------------------------------------------------------------------------

module pdcc_exposure_checker
  import pdcc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  pix_valid,
  input  wire logic                  pix_stall,
  input  wire pix_t                  pix,
  input  wire logic                  res_valid,
  input  wire logic                  res_stall,
  input  wire res_t                  res,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [ROW_W-1:0]      cfg_wdata,
  output int                         mismatches,
  output int                         outstanding
);

  localparam longint NORM_LIMIT = (longint'(1) << NORM_W) - 1;
  localparam longint OUT_MAX    = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
  localparam longint OUT_MIN    = -OUT_MAX - 1;
  localparam longint HALF_FRAC  = longint'(1) << (FRAC_BITS - 1);
  localparam longint HALF_OUT   = longint'(1) << (OUT_SHIFT - 1);

  logic [ROW_W-1:0]          coupler_row [NUM_CH];
  logic [INV_W-1:0]          inv_dmax [NUM_CH];
  logic signed [SHIFT_W-1:0] exp_shift;
  res_t                      corrected_q [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // normalize, bend, matrix product, subtract, round and saturate
  function automatic res_t correct_exposure(input pix_t p);
    logic [SAMPLE_WIDTH-1:0]        dens [NUM_CH];
    logic signed [SAMPLE_WIDTH-1:0] raw [NUM_CH];
    logic signed [SAMPLE_WIDTH-1:0] outv [NUM_CH];
    logic signed [COEF_W-1:0]       coef;
    longint                         bent [NUM_CH];
    longint                         norm, sq, acc, corr;
    res_t                           r;
    dens = '{p.dens_cyan, p.dens_magenta, p.dens_yellow};
    raw  = '{p.raw_red, p.raw_green, p.raw_blue};
    for (int k = 0; k < NUM_CH; k++) begin
      norm = (longint'(dens[k]) * longint'(inv_dmax[k]) + HALF_FRAC) >>> FRAC_BITS;
      if (norm > NORM_LIMIT) norm = NORM_LIMIT;
      sq = (norm * norm + HALF_FRAC) >>> FRAC_BITS;
      bent[k] = norm + ((longint'(exp_shift) * sq + HALF_FRAC) >>> FRAC_BITS);
    end
    for (int m = 0; m < NUM_CH; m++) begin
      acc = 0;
      for (int k = 0; k < NUM_CH; k++) begin
        coef = coupler_row[k][m*COEF_W +: COEF_W];
        acc += bent[k] * longint'(coef);
      end
      corr = ((longint'(raw[m]) <<< OUT_SHIFT) - acc + HALF_OUT) >>> OUT_SHIFT;
      if (corr > OUT_MAX) corr = OUT_MAX;
      if (corr < OUT_MIN) corr = OUT_MIN;
      outv[m] = corr[SAMPLE_WIDTH-1:0];
    end
    r.fixed_red   = outv[0];
    r.fixed_green = outv[1];
    r.fixed_blue  = outv[2];
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      for (int k = 0; k < NUM_CH; k++) begin
        coupler_row[k] = '0;
        inv_dmax[k]    = '0;
      end
      exp_shift = '0;
      corrected_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_ROW_CYAN:    coupler_row[0] = cfg_wdata;
          REG_ROW_MAGENTA: coupler_row[1] = cfg_wdata;
          REG_ROW_YELLOW:  coupler_row[2] = cfg_wdata;
          REG_INV_CYAN:    inv_dmax[0]    = cfg_wdata[INV_W-1:0];
          REG_INV_MAGENTA: inv_dmax[1]    = cfg_wdata[INV_W-1:0];
          REG_INV_YELLOW:  inv_dmax[2]    = cfg_wdata[INV_W-1:0];
          REG_SHIFT:       exp_shift      = cfg_wdata[SHIFT_W-1:0];
          default: ;
        endcase
      end
      if (res_valid && !res_stall) begin
        if (corrected_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: %h", res));
        end else begin
          want = corrected_q.pop_front();
          if (res.fixed_red !== want.fixed_red)
            report_mismatch($sformatf("fixed_red got %0d expected %0d",
                                      res.fixed_red, want.fixed_red));
          if (res.fixed_green !== want.fixed_green)
            report_mismatch($sformatf("fixed_green got %0d expected %0d",
                                      res.fixed_green, want.fixed_green));
          if (res.fixed_blue !== want.fixed_blue)
            report_mismatch($sformatf("fixed_blue got %0d expected %0d",
                                      res.fixed_blue, want.fixed_blue));
        end
      end
      if (pix_valid && !pix_stall)
        corrected_q.push_back(correct_exposure(pix));
    end
    outstanding = corrected_q.size();
  end

endmodule

// File: tb/sv/pixel_dir_coupler_correction_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_dir_coupler_correction_top_tb
// drives pixels and register writes into the coupler correction pipeline with
// random gaps on the input and random stalls on the output; a checker beside
// the block predicts every corrected pixel and counts mismatches
// ----------------------------------------------------------------------------

module pixel_dir_coupler_correction_top_tb;
  import pdcc_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RAND_PHASES   = 9;
  localparam int PHASE_PIXELS  = 150;
  localparam int QUIET_PHASE   = 4;   // phase with no gaps and no stalls
  localparam int IDLE_PCT      = 29;
  localparam int SETTLE_CYCLES = 2 * NUM_STAGES + 4;

  // address past the register list, writes there must do nothing
  localparam logic [CFG_ADDR_W-1:0] REG_NONE = 3'd7;

  localparam logic [COEF_W-1:0]  COEF_MAX  = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0]  COEF_MIN  = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic [INV_W-1:0]   INV_FULL  = '1;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX = {1'b0, {(SHIFT_W-1){1'b1}}};
  localparam logic [SHIFT_W-1:0] SHIFT_MIN = {1'b1, {(SHIFT_W-1){1'b0}}};

  // corner values cycled through by the directed pixels
  localparam logic [SAMPLE_WIDTH-1:0] RAW_CORNER [4] = '{
    {1'b0, {(SAMPLE_WIDTH-1){1'b1}}}, {1'b1, {(SAMPLE_WIDTH-1){1'b0}}},
    '0, '1
  };
  localparam logic [SAMPLE_WIDTH-1:0] DENS_CORNER [4] = '{
    '0, '1, SAMPLE_WIDTH'(1 << FRAC_BITS), {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
  };

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  pix_valid = 1'b0;
  logic                  pix_stall;
  pix_t                  pix       = '0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  res_t                  res;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [ROW_W-1:0]      cfg_wdata = '0;

  int mismatches;
  int outstanding;
  int cycles   = 0;
  bit idle_on  = 1'b1;
  bit stall_on = 1'b1;

  always #6 clk = ~clk;

  pixel_dir_coupler_correction_top dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  pdcc_exposure_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .pix_valid   (pix_valid),
    .pix_stall   (pix_stall),
    .pix         (pix),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res         (res),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // watchdog, covers a hung handshake anywhere in the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side back pressure, one decision per cycle
  always @(negedge clk) begin
    res_stall <= stall_on && ($urandom_range(99) < IDLE_PCT);
  end

  // pack three Q2.16 coefficients, red column in the low bits
  function automatic logic [ROW_W-1:0] pack_row(input logic [COEF_W-1:0] c_red,
                                                input logic [COEF_W-1:0] c_green,
                                                input logic [COEF_W-1:0] c_blue);
    return {c_blue, c_green, c_red};
  endfunction

  // mostly modest coefficients (within +-0.5), sometimes anything at all
  function automatic logic [COEF_W-1:0] rand_coef();
    if ($urandom_range(2) == 0) return COEF_W'($urandom);
    return COEF_W'(int'($urandom_range(65536)) - 32768);
  endfunction

  function automatic logic [ROW_W-1:0] rand_row();
    return pack_row(rand_coef(), rand_coef(), rand_coef());
  endfunction

  // zero reciprocal and full scale show up now and then
  function automatic logic [INV_W-1:0] rand_inv();
    case ($urandom_range(7))
      0:       return '0;
      1:       return INV_FULL;
      2:       return INV_W'($urandom);
      default: return INV_W'($urandom_range(8192));
    endcase
  endfunction

  function automatic logic [SHIFT_W-1:0] rand_shift();
    if ($urandom_range(3) == 0) return SHIFT_W'($urandom);
    return SHIFT_W'(int'($urandom_range(4096)) - 2048);
  endfunction

  // full random fields, with the density and raw ends pinned once in a while
  function automatic pix_t rand_pixel();
    pix_t p;
    p = {$urandom, $urandom, $urandom};
    if ($urandom_range(9) == 0) p.dens_cyan    = '1;
    if ($urandom_range(9) == 0) p.dens_magenta = '0;
    if ($urandom_range(9) == 0) p.dens_yellow  = '1;
    if ($urandom_range(9) == 0) p.raw_red      = RAW_CORNER[$urandom_range(3)];
    if ($urandom_range(9) == 0) p.raw_blue     = RAW_CORNER[$urandom_range(3)];
    return p;
  endfunction

  // one register write, only ever issued while the pipe is empty
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [ROW_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic load_config(input logic [ROW_W-1:0] row_c, input logic [ROW_W-1:0] row_m,
                             input logic [ROW_W-1:0] row_y, input logic [INV_W-1:0] inv_c,
                             input logic [INV_W-1:0] inv_m, input logic [INV_W-1:0] inv_y,
                             input logic [SHIFT_W-1:0] shift);
    write_reg(REG_ROW_CYAN,    row_c);
    write_reg(REG_ROW_MAGENTA, row_m);
    write_reg(REG_ROW_YELLOW,  row_y);
    write_reg(REG_INV_CYAN,    ROW_W'(inv_c));
    write_reg(REG_INV_MAGENTA, ROW_W'(inv_m));
    write_reg(REG_INV_YELLOW,  ROW_W'(inv_y));
    write_reg(REG_SHIFT,       ROW_W'(shift));
  endtask

  // present one pixel transaction, with random gaps ahead of it, and hold it
  // until the block takes it
  task automatic send_pixel(input pix_t p);
    @(negedge clk);
    if (idle_on && ($urandom_range(99) < IDLE_PCT)) begin
      pix_valid <= 1'b0;
      pix       <= rand_pixel();   // junk on the bus while idle
      do @(negedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    pix_valid <= 1'b1;
    pix       <= p;
    do @(posedge clk); while (pix_stall);
  endtask

  // directed pixels built from the corner values
  task automatic send_corner_set(input int count);
    pix_t p;
    for (int i = 0; i < count; i++) begin
      p.raw_red      = RAW_CORNER[i % 4];
      p.raw_green    = RAW_CORNER[(i + 1) % 4];
      p.raw_blue     = RAW_CORNER[(i + 2) % 4];
      p.dens_cyan    = DENS_CORNER[(i + i / 4) % 4];
      p.dens_magenta = DENS_CORNER[(i + 1) % 4];
      p.dens_yellow  = DENS_CORNER[(3 * i + 1) % 4];
      send_pixel(p);
    end
  endtask

  // drop valid and wait until every predicted pixel has come out
  task automatic drain();
    @(negedge clk);
    pix_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // registers straight out of reset: every output should equal its raw input
    send_corner_set(4);
    drain();

    // reciprocals, shift and the magenta and yellow rows at the top end, the cyan
    // row at the bottom; a write past the register list goes in as well
    load_config(pack_row(COEF_MIN, COEF_MIN, COEF_MIN),
                pack_row(COEF_MAX, COEF_MAX, COEF_MAX),
                pack_row(COEF_MAX, COEF_MAX, COEF_MAX),
                INV_FULL, INV_FULL, INV_FULL, SHIFT_MAX);
    write_reg(REG_NONE, '1);
    send_corner_set(8);
    drain();

    // most negative shift drives the bent values far negative, cyan switched
    // off by a zero reciprocal
    load_config(pack_row(COEF_MIN, COEF_MIN, COEF_MIN),
                pack_row(COEF_MAX, COEF_MAX, COEF_MAX),
                pack_row(COEF_MAX, COEF_MIN, COEF_MAX),
                '0, INV_FULL, INV_FULL, SHIFT_MIN);
    send_corner_set(8);
    drain();

    // random settings, one register set per phase
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      load_config(rand_row(), rand_row(), rand_row(),
                  rand_inv(), rand_inv(), rand_inv(), rand_shift());
      idle_on  = (ph != QUIET_PHASE);
      stall_on = (ph != QUIET_PHASE);
      for (int i = 0; i < PHASE_PIXELS; i++)
        send_pixel(rand_pixel());
      drain();
    end

    // let anything stray fall out where the checker can see it
    stall_on = 1'b0;
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
